// File: hw/rtl/hcrld_pkg.sv
package hcrld_pkg;

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int SYM_W       = 3;
    localparam int ROW_W       = 10;
    localparam int DIGIT_W     = 4;

    localparam int MAX_RUN_DEFAULT = 64;

    // configuration map
    localparam int         APB_DATA_W      = 32;
    localparam int         APB_ADDR_W      = 3;
    localparam logic       REG_ROW_WIDTH   = 1'b0;     // register index (paddr[2])
    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 10'd16;

    // character codes
    localparam logic [BYTE_W-1:0] CH_0 = 8'h30;   // '0'
    localparam logic [BYTE_W-1:0] CH_9 = 8'h39;   // '9'
    localparam logic [BYTE_W-1:0] CH_A = 8'h41;   // 'A'
    localparam logic [BYTE_W-1:0] CH_F = 8'h46;   // 'F'
    localparam logic [BYTE_W-1:0] CH_G = 8'h47;   // 'G'
    localparam logic [BYTE_W-1:0] CH_N = 8'h4E;   // 'N'

    localparam logic [DIGIT_W-1:0] HEX_TEN = 4'd10;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } t_digit;

    // request handed from parser to sequencer
    typedef struct packed {
        logic             start;
        logic [SYM_W-1:0] sym;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    function automatic t_digit decode_digit(input logic [BYTE_W-1:0] c);
        t_digit d;
        d.ok  = 1'b0;
        d.val = '0;
        if (c >= CH_0 && c <= CH_9) begin
            d.ok  = 1'b1;
            d.val = DIGIT_W'(c - CH_0);
        end else if (c >= CH_A && c <= CH_F) begin
            d.ok  = 1'b1;
            d.val = DIGIT_W'(c - CH_A) + HEX_TEN;
        end
        return d;
    endfunction

    function automatic logic is_cell(input logic [BYTE_W-1:0] c);
        return (c >= CH_G) && (c <= CH_N);
    endfunction

endpackage

// File: hw/rtl/hcrld_byte_if.sv
interface hcrld_byte_if;
    logic                          valid;
    logic                          ready;
    logic [hcrld_pkg::BYTE_W-1:0]  byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// File: hw/rtl/hcrld_cell_if.sv
interface hcrld_cell_if;
    logic                         valid;
    logic                         ready;
    logic [hcrld_pkg::SYM_W-1:0]  cell_value;
    logic                         end_of_row;
    logic                         last_of_run;

    modport source (output valid, output cell_value, output end_of_row,
                    output last_of_run, input ready);
    modport sink   (input valid, input cell_value, input end_of_row,
                    input last_of_run, output ready);
endinterface

// File: hw/rtl/hcrld_parser.sv
module hcrld_parser #(
    parameter int MAX_RUN = hcrld_pkg::MAX_RUN_DEFAULT,
    parameter int CNT_W   = $clog2(MAX_RUN + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [hcrld_pkg::BYTE_W-1:0]  i_byte,
    output hcrld_pkg::t_cmd               o_cmd,
    output logic [CNT_W-1:0]              o_reps
);
    localparam int ACC_W = CNT_W + hcrld_pkg::DIGIT_W;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_pending, n_pending;

    hcrld_pkg::t_digit dig;
    logic              letter_hit;
    logic [ACC_W-1:0]  acc;

    always_comb begin
        dig        = hcrld_pkg::decode_digit(i_byte);
        letter_hit = hcrld_pkg::is_cell(i_byte);
        // shift in next digit, msd first
        acc  = r_pending ? ({r_count, {hcrld_pkg::DIGIT_W{1'b0}}} + ACC_W'(dig.val))
                         : ACC_W'(dig.val);
        o_reps = r_pending ? r_count : CNT_W'(1);
        o_cmd.start = i_accept && letter_hit && (o_reps != '0);
        o_cmd.sym   = hcrld_pkg::SYM_W'(i_byte - hcrld_pkg::CH_G);

        n_count   = r_count;
        n_pending = r_pending;
        if (i_accept) begin
            if (dig.ok) begin
                n_count   = (acc > ACC_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : CNT_W'(acc);
                n_pending = 1'b1;
            end else begin
                // cell letter consumes the count, anything else drops it
                n_count   = '0;
                n_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pending <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_pending <= n_pending;
        end
    end
endmodule

// File: hw/rtl/hcrld_run_seq.sv
module hcrld_run_seq #(
    parameter int MAX_RUN = hcrld_pkg::MAX_RUN_DEFAULT,
    parameter int CNT_W   = $clog2(MAX_RUN + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hcrld_pkg::t_cmd              i_cmd,
    input  logic [CNT_W-1:0]             i_reps,
    input  logic [hcrld_pkg::ROW_W-1:0]  i_row_width,
    output logic                         o_idle,
    hcrld_cell_if.source                 o_cell
);
    hcrld_pkg::t_state               r_state, n_state;
    logic [CNT_W-1:0]                r_remain, n_remain;
    logic [hcrld_pkg::SYM_W-1:0]     r_sym, n_sym;
    logic [hcrld_pkg::ROW_W-1:0]     r_countdown, n_countdown;

    logic row_mark;
    logic last;

    always_comb begin
        row_mark = (r_countdown <= hcrld_pkg::ROW_W'(1));
        last     = (r_remain == CNT_W'(1));

        n_state     = r_state;
        n_remain    = r_remain;
        n_sym       = r_sym;
        n_countdown = r_countdown;

        unique case (r_state)
            hcrld_pkg::ST_IDLE: begin
                if (i_cmd.start) begin
                    n_state  = hcrld_pkg::ST_EMIT;
                    n_remain = i_reps;
                    n_sym    = i_cmd.sym;
                end
            end
            hcrld_pkg::ST_EMIT: begin
                if (o_cell.ready) begin
                    n_remain    = r_remain - CNT_W'(1);
                    n_countdown = row_mark ? i_row_width
                                           : r_countdown - hcrld_pkg::ROW_W'(1);
                    if (last) begin
                        n_state = hcrld_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = hcrld_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hcrld_pkg::ST_IDLE;
            r_countdown <= hcrld_pkg::ROW_WIDTH_RESET;
        end else begin
            r_state     <= n_state;
            r_countdown <= n_countdown;
        end
        r_remain <= n_remain;
        r_sym    <= n_sym;
    end

    assign o_idle             = (r_state == hcrld_pkg::ST_IDLE);
    assign o_cell.valid       = (r_state == hcrld_pkg::ST_EMIT);
    assign o_cell.cell_value  = r_sym;
    assign o_cell.end_of_row  = row_mark;
    assign o_cell.last_of_run = last;
endmodule

// File: hw/rtl/hex_count_run_length_decoder.sv
// Channel   Dir  Payload                                  Request moves when
// i_byte    in   byte_in[7:0]                             valid && ready
// o_cell    out  cell_value[2:0], end_of_row, last_of_run valid && ready
// apb       in   row_width at byte address 0              psel && penable && pwrite
//
// A digit or an ignored byte is taken and the input stays ready. A cell letter
// with run count N holds the block for N output requests (one per cycle without
// stalls); the input is ready again the cycle after the last cell is taken.
// Reset (synchronous, active low) clears the count, returns the sequencer to
// idle and loads the row countdown with 16. Output stalls simply hold the
// current cell; input ready stays low until the run drains.
module hex_count_run_length_decoder #(
    parameter int MAX_RUN = hcrld_pkg::MAX_RUN_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hcrld_byte_if.sink                        i_byte,
    hcrld_cell_if.source                      o_cell,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hcrld_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hcrld_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hcrld_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    localparam int CNT_W = $clog2(MAX_RUN + 1);

    logic [hcrld_pkg::ROW_W-1:0] r_row_width;
    logic                        cfg_wr;
    logic                        idle;
    logic                        in_accept;
    hcrld_pkg::t_cmd             cmd;
    logic [CNT_W-1:0]            reps;

    // config register, index comes from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == hcrld_pkg::REG_ROW_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= hcrld_pkg::ROW_WIDTH_RESET;
        end else if (cfg_wr) begin
            r_row_width <= pwdata[hcrld_pkg::ROW_W-1:0];
        end
    end

    assign prdata = (paddr[2] == hcrld_pkg::REG_ROW_WIDTH)
                  ? hcrld_pkg::APB_DATA_W'(r_row_width) : '0;

    // input is taken only while no run is being emitted
    assign i_byte.ready = idle;
    assign in_accept    = i_byte.valid && i_byte.ready;

    hcrld_parser #(
        .MAX_RUN (MAX_RUN),
        .CNT_W   (CNT_W)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_byte.byte_in),
        .o_cmd    (cmd),
        .o_reps   (reps)
    );

    hcrld_run_seq #(
        .MAX_RUN (MAX_RUN),
        .CNT_W   (CNT_W)
    ) u_run_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_reps      (reps),
        .i_row_width (r_row_width),
        .o_idle      (idle),
        .o_cell      (o_cell)
    );

    // input and output never both open
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_byte.ready |-> !o_cell.valid)
        else $error("input ready while a cell is pending");

    // last cell of a run frees the input
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell.valid && o_cell.ready && o_cell.last_of_run) |=> i_byte.ready)
        else $error("input not ready after last cell");

    // a run keeps going until its last cell
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell.valid && o_cell.ready && !o_cell.last_of_run) |=> o_cell.valid)
        else $error("run ended early");

    // a started run shows a cell next cycle
    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> (o_cell.valid && !i_byte.ready))
        else $error("cell letter did not start a run");
endmodule
